>>> sv/rv32i_instruction_step_macros.svh
// Assertion macros for the rv32i_instruction_step checker
`ifndef RV32I_INSTRUCTION_STEP_MACROS_SVH
`define RV32I_INSTRUCTION_STEP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RVIS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rvis check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define RVIS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rvis check failed");

`endif

>>> sv/rvis_pkg.sv
// Types and constants shared by the RV32I step core
`default_nettype none
package rvis_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_MEM,
    ST_DONE
  } state_t;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
  localparam logic [31:0] JALR_MASK  = 32'hFFFF_FFFE;
  localparam logic [31:0] PC_LIMIT_RESET = 32'h0000_2000;
  localparam logic [31:0] SP_RESET = 32'h0000_3FFC;
  localparam logic [31:0] GP_RESET = 32'h0000_1800;

  localparam logic [4:0] REG_SP = 5'd2;
  localparam logic [4:0] REG_GP = 5'd3;
  localparam logic [4:0] REG_A0 = 5'd10;
  localparam logic [4:0] REG_A7 = 5'd17;

  localparam logic [31:0] SYS_PRINT_INT = 32'd1;
  localparam logic [31:0] SYS_PRINT_STR = 32'd4;
  localparam logic [31:0] SYS_EXIT      = 32'd10;

  localparam logic [2:0] CALL_NONE  = 3'd0;
  localparam logic [2:0] CALL_INT   = 3'd1;
  localparam logic [2:0] CALL_STR   = 3'd2;
  localparam logic [2:0] CALL_EXIT  = 3'd3;
  localparam logic [2:0] CALL_OTHER = 3'd4;

  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  typedef struct packed {
    logic        wr;
    logic [31:0] val;
    logic [31:0] npc;
    logic        is_load;
    logic        is_store;
    logic [31:0] addr;
    logic [2:0]  call_event;
    logic [31:0] call_arg;
    logic        stop;
  } exec_t;

  typedef struct packed {
    logic        ld_ok;
    logic [31:0] ld_val;
    logic        st_ok;
    logic [31:0] st_word;
    logic [13:0] byte_addr;
  } lsu_t;

  typedef struct packed {
    logic        halted;
    logic [31:0] call_arg;
    logic [2:0]  call_event;
    logic [13:0] mem_byte_addr;
    logic        mem_written;
    logic [31:0] reg_value;
    logic [4:0]  reg_index;
    logic        reg_written;
    logic [31:0] next_pc;
    logic [31:0] done_pc;
  } res_t;

  localparam int RES_W = $bits(res_t);
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

endpackage
`default_nettype wire

>>> sv/rvis_mem.sv
// Unified program and data memory, one write and one registered read port
`default_nettype none
module rvis_mem #(
  parameter int MEM_WORDS = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(MEM_WORDS)-1:0] waddr,
  input  wire logic [31:0]                  wdata,
  input  wire logic [$clog2(MEM_WORDS)-1:0] raddr,
  output logic      [31:0]                  rdata
);

  logic [31:0] mem [MEM_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/rvis_regfile.sv
// Integer register file, two registered read ports, reset values via valid bits
`default_nettype none
module rvis_regfile (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [4:0]  ra,
  input  wire logic [4:0]  rb,
  output logic      [31:0] rdata_a,
  output logic      [31:0] rdata_b,
  input  wire logic        we,
  input  wire logic [4:0]  wa,
  input  wire logic [31:0] wd
);

  logic [31:0] mem [32];
  logic [31:0] valid_r;
  logic [4:0]  ra_r;
  logic [4:0]  rb_r;
  logic [31:0] raw_a_r;
  logic [31:0] raw_b_r;

  function automatic logic [31:0] rst_val(input logic [4:0] idx);
    logic [31:0] v;
    v = '0;
    if (idx == rvis_pkg::REG_SP) begin
      v = rvis_pkg::SP_RESET;
    end else if (idx == rvis_pkg::REG_GP) begin
      v = rvis_pkg::GP_RESET;
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (we && (wa != 5'd0)) begin
      mem[wa] <= wd;
    end
    raw_a_r <= mem[ra];
    raw_b_r <= mem[rb];
    ra_r    <= ra;
    rb_r    <= rb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we && (wa != 5'd0)) begin
      valid_r[wa] <= 1'b1;
    end
  end

  assign rdata_a = valid_r[ra_r] ? raw_a_r : rst_val(ra_r);
  assign rdata_b = valid_r[rb_r] ? raw_b_r : rst_val(rb_r);

endmodule
`default_nettype wire

>>> sv/rvis_exec.sv
// Decode and execute of one RV32I instruction
`default_nettype none
module rvis_exec (
  input  wire logic [31:0]    ir,
  input  wire logic [31:0]    pc,
  input  wire logic [31:0]    a,
  input  wire logic [31:0]    b,
  output rvis_pkg::exec_t     ex
);

  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;
  logic [31:0] opnd;
  logic [4:0]  sh;
  logic [31:0] sll;
  logic [31:0] srl;
  logic [31:0] sra;
  logic        lts;
  logic        ltu;
  logic        take;
  logic        bok;

  assign op    = ir[6:0];
  assign f3    = ir[14:12];
  assign f7    = ir[31:25];
  assign imm_i = {{20{ir[31]}}, ir[31:20]};
  assign imm_s = {{20{ir[31]}}, ir[31:25], ir[11:7]};
  assign imm_b = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
  assign imm_j = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
  assign imm_u = {ir[31:12], 12'b0};
  assign opnd  = (op == rvis_pkg::OP_REG) ? b : imm_i;
  assign sh    = (op == rvis_pkg::OP_REG) ? b[4:0] : ir[24:20];
  assign sll   = a << sh;
  assign srl   = a >> sh;
  assign sra   = $signed(a) >>> sh;
  assign lts   = $signed(a) < $signed(opnd);
  assign ltu   = a < opnd;

  always_comb begin
    take = 1'b0;
    bok  = 1'b1;
    case (f3)
      3'd0:    take = (a == b);
      3'd1:    take = (a != b);
      3'd4:    take = ($signed(a) < $signed(b));
      3'd5:    take = !($signed(a) < $signed(b));
      3'd6:    take = (a < b);
      3'd7:    take = (a >= b);
      default: bok  = 1'b0;
    endcase
  end

  always_comb begin
    ex     = '0;
    ex.npc = pc + 32'd4;
    ex.addr = a + imm_i;
    case (op)
      rvis_pkg::OP_LUI: begin
        ex.wr  = 1'b1;
        ex.val = imm_u;
      end
      rvis_pkg::OP_AUIPC: begin
        ex.wr  = 1'b1;
        ex.val = pc + imm_u;
      end
      rvis_pkg::OP_JAL: begin
        ex.wr  = 1'b1;
        ex.val = pc + 32'd4;
        ex.npc = pc + imm_j;
      end
      rvis_pkg::OP_JALR: begin
        if (f3 == 3'd0) begin
          ex.wr  = 1'b1;
          ex.val = pc + 32'd4;
          ex.npc = (a + imm_i) & rvis_pkg::JALR_MASK;
        end
      end
      rvis_pkg::OP_BRANCH: begin
        if (bok && take) begin
          ex.npc = pc + imm_b;
        end
      end
      rvis_pkg::OP_LOAD: begin
        ex.is_load = 1'b1;
      end
      rvis_pkg::OP_STORE: begin
        ex.is_store = 1'b1;
        ex.addr     = a + imm_s;
      end
      rvis_pkg::OP_IMM: begin
        ex.wr = 1'b1;
        case (f3)
          3'd0: ex.val = a + imm_i;
          3'd2: ex.val = {31'b0, lts};
          3'd3: ex.val = {31'b0, ltu};
          3'd4: ex.val = a ^ imm_i;
          3'd6: ex.val = a | imm_i;
          3'd7: ex.val = a & imm_i;
          3'd1: begin
            ex.wr  = (f7 == rvis_pkg::F7_ZERO);
            ex.val = sll;
          end
          default: begin
            ex.wr  = (f7 == rvis_pkg::F7_ZERO) || (f7 == rvis_pkg::F7_ALT);
            ex.val = (f7 == rvis_pkg::F7_ALT) ? sra : srl;
          end
        endcase
      end
      rvis_pkg::OP_REG: begin
        if (f7 == rvis_pkg::F7_ZERO) begin
          ex.wr = 1'b1;
          case (f3)
            3'd0:    ex.val = a + b;
            3'd1:    ex.val = sll;
            3'd2:    ex.val = {31'b0, lts};
            3'd3:    ex.val = {31'b0, ltu};
            3'd4:    ex.val = a ^ b;
            3'd5:    ex.val = srl;
            3'd6:    ex.val = a | b;
            default: ex.val = a & b;
          endcase
        end else if ((f7 == rvis_pkg::F7_ALT) && (f3 == 3'd0)) begin
          ex.wr  = 1'b1;
          ex.val = a - b;
        end else if ((f7 == rvis_pkg::F7_ALT) && (f3 == 3'd5)) begin
          ex.wr  = 1'b1;
          ex.val = sra;
        end
      end
      rvis_pkg::OP_SYSTEM: begin
        if (ir == rvis_pkg::ECALL_WORD) begin
          ex.call_arg = a;
          if (b == rvis_pkg::SYS_PRINT_INT) begin
            ex.call_event = rvis_pkg::CALL_INT;
          end else if (b == rvis_pkg::SYS_PRINT_STR) begin
            ex.call_event = rvis_pkg::CALL_STR;
          end else if (b == rvis_pkg::SYS_EXIT) begin
            ex.call_event = rvis_pkg::CALL_EXIT;
            ex.stop       = 1'b1;
          end else begin
            ex.call_event = rvis_pkg::CALL_OTHER;
          end
        end
      end
      default: ex.wr = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/rvis_lsu.sv
// Load extraction and store merge for byte, half and word accesses
`default_nettype none
module rvis_lsu #(
  parameter int MEM_WORDS = 4096
) (
  input  wire logic [2:0]  f3,
  input  wire logic [31:0] addr,
  input  wire logic [31:0] w,
  input  wire logic [31:0] b,
  output rvis_pkg::lsu_t   ls
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [31:0] bsel;
  logic [15:0] hsel;
  logic [4:0]  bsh;
  logic [4:0]  hsh;
  logic [1:0]  lane;

  assign bsh  = {addr[1:0], 3'b000};
  assign hsh  = {addr[1], 4'b0000};
  assign bsel = w >> bsh;
  assign hsel = addr[1] ? w[31:16] : w[15:0];

  always_comb begin
    ls   = '0;
    lane = 2'd0;
    case (f3)
      3'd0: begin
        ls.ld_ok  = 1'b1;
        ls.ld_val = {{24{bsel[7]}}, bsel[7:0]};
      end
      3'd1: begin
        ls.ld_ok  = 1'b1;
        ls.ld_val = {{16{hsel[15]}}, hsel};
      end
      3'd2: begin
        ls.ld_ok  = 1'b1;
        ls.ld_val = w;
      end
      3'd4: begin
        ls.ld_ok  = 1'b1;
        ls.ld_val = {24'b0, bsel[7:0]};
      end
      3'd5: begin
        ls.ld_ok  = 1'b1;
        ls.ld_val = {16'b0, hsel};
      end
      default: ls.ld_ok = 1'b0;
    endcase
    case (f3)
      3'd0: begin
        ls.st_ok   = 1'b1;
        lane       = addr[1:0];
        ls.st_word = (w & ~(32'h0000_00FF << bsh)) | ({24'b0, b[7:0]} << bsh);
      end
      3'd1: begin
        ls.st_ok   = 1'b1;
        lane       = {addr[1], 1'b0};
        ls.st_word = (w & ~(32'h0000_FFFF << hsh)) | ({16'b0, b[15:0]} << hsh);
      end
      3'd2: begin
        ls.st_ok   = 1'b1;
        ls.st_word = b;
      end
      default: ls.st_ok = 1'b0;
    endcase
    ls.byte_addr = 14'({addr[AW+1:2], lane});
  end

endmodule
`default_nettype wire

>>> sv/rv32i_instruction_step.sv
// RV32I step core: top level with sequencer, memory, register file and output register
//
// Each input item either writes one memory word (tuser 0) or executes one RV32I
// instruction at the current pc (tuser 1), and yields exactly one result item.
// Fetch and data access share one synchronous memory port, so an instruction
// passes through fetch, register read, execute and result, and loads and stores
// add a second memory read before the write-back. A word write, or a step while
// halted or with pc above pc_limit, goes straight to the result. One item is in
// flight at a time; the next item is accepted while the result waits in the
// output register. After reset a clearing pass zeroes the memory with in_tready
// low; pc_limit writes are taken throughout. MEM_WORDS must be a power of two.
`default_nettype none
module rv32i_instruction_step #(
  parameter int MEM_WORDS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // load_index[11:0], load_word[43:12], zero fill
  input  wire logic        in_tuser,  // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // done_pc[31:0], next_pc[63:32], reg_written[64], reg_index[69:65],
  // reg_value[101:70], mem_written[102], mem_byte_addr[116:103],
  // call_event[119:117], call_arg[151:120], halted[152], zero fill
  output logic [rvis_pkg::OUT_W-1:0] out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  localparam int AW = $clog2(MEM_WORDS);

  rvis_pkg::state_t state_r, state_nxt;
  logic [31:0]      pc_r, pc_nxt;
  logic             stop_r, stop_nxt;
  logic [31:0]      limit_r;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [31:0]      ir_r, ir_nxt;
  logic [31:0]      addr_r, addr_nxt;
  rvis_pkg::res_t   res_r, res_nxt;
  rvis_pkg::res_t   out_res_r;
  logic             out_valid_r;
  logic             out_load;

  logic             in_acc;
  logic             halt_now;

  logic             m_we;
  logic [AW-1:0]    m_waddr;
  logic [31:0]      m_wdata;
  logic [AW-1:0]    m_raddr;
  logic [31:0]      m_rdata;

  logic [31:0]      rf_src;
  logic [4:0]       rf_ra;
  logic [4:0]       rf_rb;
  logic [31:0]      rf_a;
  logic [31:0]      rf_b;
  logic             rf_we;
  logic [4:0]       rf_wa;
  logic [31:0]      rf_wd;

  rvis_pkg::exec_t  ex;
  rvis_pkg::lsu_t   ls;

  rvis_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  rvis_regfile u_rf (
    .clk     (clk),
    .rst_n   (rst_n),
    .ra      (rf_ra),
    .rb      (rf_rb),
    .rdata_a (rf_a),
    .rdata_b (rf_b),
    .we      (rf_we),
    .wa      (rf_wa),
    .wd      (rf_wd)
  );

  rvis_exec u_exec (
    .ir (ir_r),
    .pc (pc_r),
    .a  (rf_a),
    .b  (rf_b),
    .ex (ex)
  );

  rvis_lsu #(.MEM_WORDS(MEM_WORDS)) u_lsu (
    .f3   (ir_r[14:12]),
    .addr (addr_r),
    .w    (m_rdata),
    .b    (rf_b),
    .ls   (ls)
  );

  assign in_tready  = (state_r == rvis_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign halt_now   = stop_r || (pc_r > limit_r);
  assign out_load   = (state_r == rvis_pkg::ST_DONE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(rvis_pkg::OUT_W - rvis_pkg::RES_W){1'b0}}, out_res_r};

  assign rf_src = (state_r == rvis_pkg::ST_FETCH) ? m_rdata : ir_r;
  assign rf_ra  = (rf_src == rvis_pkg::ECALL_WORD) ? rvis_pkg::REG_A0 : rf_src[19:15];
  assign rf_rb  = (rf_src == rvis_pkg::ECALL_WORD) ? rvis_pkg::REG_A7 : rf_src[24:20];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rvis_pkg::ST_CLEAR: begin
        if (clr_r == AW'(MEM_WORDS - 1)) begin
          state_nxt = rvis_pkg::ST_IDLE;
        end
      end
      rvis_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!in_tuser || halt_now) begin
            state_nxt = rvis_pkg::ST_DONE;
          end else begin
            state_nxt = rvis_pkg::ST_FETCH;
          end
        end
      end
      rvis_pkg::ST_FETCH: state_nxt = rvis_pkg::ST_EXEC;
      rvis_pkg::ST_EXEC: begin
        if (ex.is_load || ex.is_store) begin
          state_nxt = rvis_pkg::ST_MEM;
        end else begin
          state_nxt = rvis_pkg::ST_DONE;
        end
      end
      rvis_pkg::ST_MEM: state_nxt = rvis_pkg::ST_DONE;
      rvis_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = rvis_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rvis_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pc_nxt   = pc_r;
    stop_nxt = stop_r;
    clr_nxt  = clr_r;
    ir_nxt   = ir_r;
    addr_nxt = addr_r;
    res_nxt  = res_r;
    m_we     = 1'b0;
    m_waddr  = addr_r[AW+1:2];
    m_wdata  = ls.st_word;
    m_raddr  = pc_r[AW+1:2];
    rf_we    = 1'b0;
    rf_wa    = ir_r[11:7];
    rf_wd    = ex.val;
    case (state_r)
      rvis_pkg::ST_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_r;
        m_wdata = '0;
        clr_nxt = clr_r + AW'(1);
      end
      rvis_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_nxt         = '0;
          res_nxt.done_pc = pc_r;
          res_nxt.next_pc = pc_r;
          res_nxt.halted  = stop_r;
          if (!in_tuser) begin
            m_we    = 1'b1;
            m_waddr = AW'(in_tdata[11:0]);
            m_wdata = in_tdata[43:12];
          end else if (halt_now) begin
            stop_nxt       = 1'b1;
            res_nxt.halted = 1'b1;
          end
        end
      end
      rvis_pkg::ST_FETCH: begin
        ir_nxt = m_rdata;
      end
      rvis_pkg::ST_EXEC: begin
        addr_nxt = ex.addr;
        m_raddr  = ex.addr[AW+1:2];
        if (!ex.is_load && !ex.is_store) begin
          pc_nxt             = ex.npc;
          stop_nxt           = stop_r || ex.stop;
          res_nxt.next_pc    = ex.npc;
          res_nxt.halted     = stop_r || ex.stop;
          res_nxt.call_event = ex.call_event;
          res_nxt.call_arg   = ex.call_arg;
          if (ex.wr && (ir_r[11:7] != 5'd0)) begin
            rf_we               = 1'b1;
            res_nxt.reg_written = 1'b1;
            res_nxt.reg_index   = ir_r[11:7];
            res_nxt.reg_value   = ex.val;
          end
        end
      end
      rvis_pkg::ST_MEM: begin
        pc_nxt          = ex.npc;
        res_nxt.next_pc = ex.npc;
        res_nxt.halted  = stop_r;
        rf_wd           = ls.ld_val;
        if (ex.is_load && ls.ld_ok && (ir_r[11:7] != 5'd0)) begin
          rf_we               = 1'b1;
          res_nxt.reg_written = 1'b1;
          res_nxt.reg_index   = ir_r[11:7];
          res_nxt.reg_value   = ls.ld_val;
        end
        if (ex.is_store && ls.st_ok) begin
          m_we                  = 1'b1;
          res_nxt.mem_written   = 1'b1;
          res_nxt.mem_byte_addr = ls.byte_addr;
        end
      end
      default: m_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rvis_pkg::ST_CLEAR;
      pc_r        <= '0;
      stop_r      <= 1'b0;
      clr_r       <= '0;
      limit_r     <= rvis_pkg::PC_LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      stop_r  <= stop_nxt;
      clr_r   <= clr_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ir_r   <= ir_nxt;
    addr_r <= addr_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_res_r <= res_r;
    end
  end

endmodule
`default_nettype wire

>>> sv/rvis_checker.sv
// Port-level checks for the RV32I step core, bound to the top level
`default_nettype none
`include "rv32i_instruction_step_macros.svh"
module rvis_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [159:0] out_tdata
);

  `RVIS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `RVIS_ASSERT_NXT(a_one_item, in_tvalid && in_tready, !in_tready)
  `RVIS_ASSERT_IMP(a_store_only, out_tvalid && out_tdata[102], !out_tdata[64] && (out_tdata[119:117] == 3'd0))
  `RVIS_ASSERT_IMP(a_no_reg_zero, out_tvalid && !out_tdata[64], (out_tdata[69:65] == 5'd0) && (out_tdata[101:70] == 32'd0))

endmodule

bind rv32i_instruction_step rvis_checker u_rvis_checker (.*);
`default_nettype wire
